// ===== rtl/core/sha256_pkg.sv =====
// SHA-256 package: state encoding, round constants, initial hash values and
// the sigma functions used by the message hasher core.
// No dependencies.
package sha256_pkg;

	localparam int WordW = 32;
	localparam int Rounds = 64;
	localparam int BlockBytes = 64;
	localparam int LenBytePos = 56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND_W,
		ST_ROUND_C,
		ST_UPDATE,
		ST_OUT
	} hash_state_t;

	localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int n);
		rotr = (v >> n) | (v << (WordW - n));
	endfunction

	function automatic logic [WordW-1:0] sig0(input logic [WordW-1:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WordW-1:0] sig1(input logic [WordW-1:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== rtl/core/sha256_message_hasher.sv =====
// A byte that does not complete a block is taken at once and leaves the block
// idle; a byte that completes a block is followed by a busy phase of 64 rounds,
// each a schedule step and a compression step on the single shared round unit,
// then one hash update. Finish pads one byte per cycle while in the pad state,
// compresses one or two blocks, then offers the eight digest words in eight
// transactions. Reset clears all control state and reloads the initial hash values.
// SHA-256 message hasher top level. Depends on sha256_pkg.
module sha256_message_hasher
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  message_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// Controller state and its next value.
	hash_state_t state_q, state_d;

	// Hash state, round variables a..h, and the sixteen-word schedule window.
	// The window is a shift line: word 0 is the oldest, word 15 the newest.
	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] w_q [16];
	logic [23:0] pack_q;       // bytes of the word still being assembled
	logic [31:0] wk_q;         // schedule word plus round constant
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic [63:0] len_q;        // bit length, shifted out a byte at a time
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        finishing_q;  // a finish transaction is being processed
	logic        pad_first_q;  // next pad byte is the 0x80 marker
	logic        lenok_q;      // current block is the last: length goes in
	logic        final_q;      // compression in flight is the final one

	logic        in_acc, out_acc;
	logic        byte_wr, go_comp, lenok_now;
	logic [7:0]  pad_byte, byte_val;
	logic [31:0] wt, t1, t2;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Bytes come either from an append transaction or from the padding
	// sequencer; both go down the same packing path.
	assign lenok_now = pad_first_q ? (fill_q < 6'(LenBytePos)) : lenok_q;
	always_comb begin
		if (pad_first_q) begin
			pad_byte = 8'h80;
		end else if (lenok_q && fill_q >= 6'(LenBytePos)) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end
	assign byte_wr  = (in_acc && !func) || (state_q == ST_PAD);
	assign byte_val = (state_q == ST_PAD) ? pad_byte : message_byte;
	assign go_comp  = byte_wr && (fill_q == 6'(BlockBytes - 1));

	// Schedule word: the first sixteen rounds recirculate the loaded words,
	// later rounds extend the schedule from the window taps.
	assign wt = (rnd_q < 6'd16) ? w_q[0] :
		w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);

	assign t1 = work_q[7] + bsig1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6])) + wk_q;
	assign t2 = bsig0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func) begin
						state_d = ST_PAD;
					end else if (go_comp) begin
						state_d = ST_ROUND_W;
					end
				end
			end
			ST_PAD: begin
				if (go_comp) begin
					state_d = ST_ROUND_W;
				end
			end
			ST_ROUND_W: state_d = ST_ROUND_C;
			ST_ROUND_C: begin
				state_d = (rnd_q == 6'(Rounds - 1)) ? ST_UPDATE : ST_ROUND_W;
			end
			ST_UPDATE: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (finishing_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_acc && oidx_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			total_q     <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			finishing_q <= 1'b0;
			pad_first_q <= 1'b0;
			lenok_q     <= 1'b0;
			final_q     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else begin
			if (in_acc && !func) begin
				total_q <= total_q + 64'd1;
			end
			if (in_acc && func) begin
				finishing_q <= 1'b1;
				pad_first_q <= 1'b1;
			end
			if (byte_wr) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == ST_PAD) begin
				pad_first_q <= 1'b0;
				lenok_q     <= lenok_now;
			end
			if (go_comp) begin
				final_q <= (state_q == ST_PAD) && lenok_now;
			end
			if (state_q == ST_ROUND_C) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_UPDATE) begin
				lenok_q <= 1'b1;
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + work_q[i];
				end
			end
			if (out_acc) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					finishing_q <= 1'b0;
					lenok_q     <= 1'b0;
					final_q     <= 1'b0;
					total_q     <= '0;
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= INIT_HASH[i];
					end
				end
			end
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc && func) begin
			len_q <= {total_q[60:0], 3'b000};
		end else if (state_q == ST_PAD && !pad_first_q && lenok_q
				&& fill_q >= 6'(LenBytePos)) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (byte_wr) begin
			pack_q <= {pack_q[15:0], byte_val};
			if (fill_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= {pack_q, byte_val};
			end
		end
		if (go_comp) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end
		if (state_q == ST_ROUND_W) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wt;
			wk_q    <= wt + ROUND_K[rnd_q];
		end
		if (state_q == ST_ROUND_C) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = hash_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

`ifndef SYNTHESIS
	a_stall_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while digest pending");
	a_fill_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 6'd0)) else $error("fill not empty at output");
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_PAD) |-> (rnd_q == 6'd0))
		else $error("round counter not cleared");
	a_update_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> $past(state_q == ST_ROUND_C && rnd_q == 6'd63))
		else $error("hash update out of sequence");
`endif

endmodule

// ===== tb/sha256_message_hasher_test.sv =====
// Self-checking testbench for the SHA-256 message hasher: drives byte and finish
// transactions, predicts the digest words and compares every output transaction.
// Depends on sha256_pkg and sha256_message_hasher.
module sha256_message_hasher_test;
	import sha256_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	// Holds the running hash of the current message and the queue of digest
	// words that the block still owes us.
	class digest_scoreboard;
		logic [31:0]  chain [8];
		logic [7:0]   pending [64];
		int unsigned  fill;
		logic [63:0]  total_bytes;
		digest_beat_t owed [$];
		int           errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			foreach (chain[i]) chain[i] = INIT_HASH[i];
			fill = 0;
			total_bytes = '0;
		endfunction

		static function logic [31:0] ror(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] x, s0, s1, t1, t2, ch, mj;
			for (int j = 0; j < 8; j++) v[j] = chain[j];
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					x = {pending[4*t], pending[4*t+1], pending[4*t+2], pending[4*t+3]};
				end else begin
					s0 = ror(w[(t-15)%16], 7) ^ ror(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
					s1 = ror(w[(t-2)%16], 17) ^ ror(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
					x = w[t%16] + s0 + w[(t-7)%16] + s1;
				end
				w[t%16] = x;
				s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_K[t] + x;
				s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2 = s0 + mj;
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int j = 0; j < 8; j++) chain[j] += v[j];
		endfunction

		function void note_input(logic fn, logic [7:0] b);
			logic [63:0] bits;
			int p;
			digest_beat_t e;
			if (fn == FUNC_APPEND) begin
				pending[fill] = b;
				fill++;
				total_bytes++;
				if (fill == 64) begin
					compress();
					fill = 0;
				end
			end else begin
				bits = total_bytes << 3;
				p = fill;
				pending[p++] = 8'h80;
				if (p > LenBytePos) begin
					while (p < 64) pending[p++] = 8'h00;
					compress();
					p = 0;
				end
				while (p < LenBytePos) pending[p++] = 8'h00;
				for (int i = 0; i < 8; i++) pending[63-i] = bits[8*i +: 8];
				compress();
				for (int i = 0; i < 8; i++) begin
					e.digest_word = chain[i];
					e.word_index = 3'(i);
					e.last_word = (i == 7);
					owed.push_back(e);
				end
				restart();
			end
		endfunction

		function void check_result(digest_beat_t got);
			digest_beat_t e;
			if (owed.size() == 0) begin
				report("unexpected digest transaction", got, got);
				return;
			end
			e = owed.pop_front();
			if (got.digest_word !== e.digest_word) report("digest_word", got, e);
			if (got.word_index !== e.word_index) report("word_index", got, e);
			if (got.last_word !== e.last_word) report("last_word", got, e);
		endfunction

		function void report(string what, digest_beat_t got, digest_beat_t e);
			errors++;
			$display("mismatch %s: got %h/%0d/%0b expected %h/%0d/%0b", what,
				got.digest_word, got.word_index, got.last_word,
				e.digest_word, e.word_index, e.last_word);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  message_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_scoreboard sb = new();
	// Percentages of cycles in which the sender idles or the receiver stalls.
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	sha256_message_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .message_byte(message_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver: the stall is redrawn every cycle and each accepted digest
	// transaction is checked against the oldest owed word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall)
				sb.check_result({digest_word, word_index, last_word});
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offers one transaction, with a random idle gap first, and holds it until
	// the block accepts it. Valid stays high into the next item unless that item draws an idle gap.
	task automatic send_item(logic fn, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		message_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(fn, b);
	endtask

	task automatic send_message(int unsigned len, bit walk);
		for (int unsigned i = 0; i < len; i++)
			send_item(FUNC_APPEND, walk ? 8'(i * 37) : 8'($urandom_range(255)));
		send_item(FUNC_FINISH, 8'($urandom_range(255)));
	endtask

	initial begin
		int unsigned len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_APPEND;
		message_byte = 8'h00;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages: empty, byte extremes, and lengths around the
		// point where padding spills into a second block, also around a
		// full block. The empty one hashes the padding alone.
		send_item(FUNC_FINISH, 8'hff);
		send_item(FUNC_APPEND, 8'h00);
		send_item(FUNC_APPEND, 8'hff);
		send_item(FUNC_APPEND, 8'h55);
		send_item(FUNC_APPEND, 8'haa);
		send_item(FUNC_FINISH, 8'h00);
		send_message(55, 1);
		send_message(56, 1);
		send_message(63, 0);
		send_message(64, 0);

		// Random messages in four idling phases; most are short, some cross
		// block boundaries so that chained compressions get exercised.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 69 : (ph == 3 ? 23 : 0);
			stall_pct = (ph == 2) ? 69 : 0;
			if (ph == 3) begin
				send_idle_pct = 23;
				stall_pct = 23;
			end
			for (int k = 0; k < 36; k += len + 1) begin
				case ($urandom_range(3))
					0: len = $urandom_range(3);
					1: len = $urandom_range(70, 50);
					default: len = $urandom_range(30);
				endcase
				send_message(len, 0);
			end
		end
		in_valid <= 1'b0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Each byte costs at most one block compression plus idles and stalls.
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sha256_message_hasher.f =====
rtl/core/sha256_pkg.sv
rtl/core/sha256_message_hasher.sv
tb/sha256_message_hasher_test.sv
